@@ sv/bxds_pkg.sv @@
// Shared types, constants and the reciprocal table for the box-average downscaler.
// Used by every module of the block; depends on nothing.
package bxds_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_SCALE    = 16;
  localparam int HEIGHT_LIMIT = 2048;

  localparam int CH_W     = 8;
  localparam int SUM_W    = 16;
  localparam int SCALE_W  = 5;
  localparam int DIM_W    = 12;
  localparam int BX_W     = $clog2(MAX_WIDTH);
  localparam int POS_W    = DIM_W + 1;
  localparam int RECIP_W  = 25;
  localparam int RECIP_SH = 24;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW  = $clog2(FIFO_DEPTH);
  localparam int CNT_W    = FIFO_AW + 1;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic            acc;
    logic            restart;
    logic            act;
    logic            blk_end;
    logic            first;
    logic            row_wrap;
    logic [BX_W-1:0] bx;
  } lane_ctl_t;

  typedef struct packed {
    logic vld;
    logic row_end;
    logic frame_end;
  } tag_t;

  typedef struct packed {
    logic [CH_W-1:0] avg_blue;
    logic [CH_W-1:0] avg_green;
    logic [CH_W-1:0] avg_red;
    logic            row_end;
    logic            frame_end;
  } out_word_t;

  // ceil(2^24 / (s*s)); exact floor division of any 16-bit sum by s*s
  function automatic logic [RECIP_W-1:0] recip_of(input logic [SCALE_W-1:0] s);
    logic [RECIP_W-1:0] r;
    begin
      case (s)
        5'd2:    r = 25'd4194304;
        5'd3:    r = 25'd1864136;
        5'd4:    r = 25'd1048576;
        5'd5:    r = 25'd671089;
        5'd6:    r = 25'd466034;
        5'd7:    r = 25'd342393;
        5'd8:    r = 25'd262144;
        5'd9:    r = 25'd207127;
        5'd10:   r = 25'd167773;
        5'd11:   r = 25'd138655;
        5'd12:   r = 25'd116509;
        5'd13:   r = 25'd99274;
        5'd14:   r = 25'd85599;
        5'd15:   r = 25'd74566;
        5'd16:   r = 25'd65536;
        default: r = 25'd16777216;
      endcase
      return r;
    end
  endfunction

endpackage

@@ sv/box_average_downscaler_top.sv @@
// Box-average downscaler: three channel lanes behind one position controller.
// From a block's last pixel: block sum, column sum, product, output queue.
// Throughput: one pixel per cycle; input stalls only when the 8-word output
// queue plus words in the 3-stage mean pipeline would overflow.
// Reset: scale 1, width 640, height 480, counters and queue cleared; the
// column store is not cleared, every entry is written before it is read.
module box_average_downscaler_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bxds_pkg::CH_W-1:0]          in_blue,
  input  logic [bxds_pkg::CH_W-1:0]          in_green,
  input  logic [bxds_pkg::CH_W-1:0]          in_red,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bxds_pkg::CH_W-1:0]          out_avg_blue,
  output logic [bxds_pkg::CH_W-1:0]          out_avg_green,
  output logic [bxds_pkg::CH_W-1:0]          out_avg_red,
  output logic                               out_row_end,
  output logic                               out_frame_end,
  input  logic                               cfg_we,
  input  logic [bxds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bxds_pkg::DIM_W-1:0]         cfg_data
);

  bxds_pkg::lane_ctl_t           ctl;
  bxds_pkg::tag_t                tag;
  bxds_pkg::out_word_t           word;
  logic [bxds_pkg::RECIP_W-1:0]  recip;
  logic [1:0]                    inflight;
  logic [bxds_pkg::CNT_W-1:0]    cnt;
  logic [bxds_pkg::CH_W-1:0]     avg_b, avg_g, avg_r;
  logic                          acc;
  logic                          pop;

  assign in_stall  = ({1'b0, cnt} + (bxds_pkg::CNT_W + 1)'(inflight)) >=
                     (bxds_pkg::CNT_W + 1)'(bxds_pkg::FIFO_DEPTH);
  assign acc       = in_valid && !in_stall;
  assign out_valid = (cnt != '0);
  assign pop       = out_valid && !out_stall;

  bxds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .recip     (recip),
    .tag       (tag),
    .inflight  (inflight)
  );

  bxds_lane u_lane_blue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .px    (in_blue),
    .recip (recip),
    .avg   (avg_b)
  );

  bxds_lane u_lane_green (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .px    (in_green),
    .recip (recip),
    .avg   (avg_g)
  );

  bxds_lane u_lane_red (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .px    (in_red),
    .recip (recip),
    .avg   (avg_r)
  );

  bxds_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag       (tag),
    .avg_blue  (avg_b),
    .avg_green (avg_g),
    .avg_red   (avg_r),
    .pop       (pop),
    .word      (word),
    .cnt       (cnt)
  );

  assign out_avg_blue  = word.avg_blue;
  assign out_avg_green = word.avg_green;
  assign out_avg_red   = word.avg_red;
  assign out_row_end   = word.row_end;
  assign out_frame_end = word.frame_end;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    tag.vld |-> (cnt < bxds_pkg::CNT_W'(bxds_pkg::FIFO_DEPTH)))
    else $error("output queue overflow");

  a_frame_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_frame_end || out_row_end))
    else $error("frame end without row end");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && inflight == 2'd0))
    else $error("words left after reset");

endmodule

@@ sv/bxds_ctrl.sv @@
// Configuration registers, raster position counters and block tracking.
// Drives the lane control word and the flag pipeline; uses bxds_pkg.
module bxds_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                acc,
  input  logic                                cfg_we,
  input  logic [bxds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bxds_pkg::DIM_W-1:0]          cfg_data,
  output bxds_pkg::lane_ctl_t                 ctl,
  output logic [bxds_pkg::RECIP_W-1:0]        recip,
  output bxds_pkg::tag_t                      tag,
  output logic [1:0]                          inflight
);

  logic [bxds_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic [bxds_pkg::DIM_W-1:0]   width_r, width_nxt;
  logic [bxds_pkg::DIM_W-1:0]   height_r, height_nxt;
  logic                         restart;

  logic [bxds_pkg::SCALE_W-1:0] s_eff;
  logic [bxds_pkg::DIM_W-1:0]   w_eff;
  logic [bxds_pkg::DIM_W-1:0]   h_eff;

  logic [bxds_pkg::BX_W-1:0]    pcol_r, pcol_nxt;
  logic [bxds_pkg::BX_W-1:0]    prow_r, prow_nxt;
  logic [3:0]                   wbc_r, wbc_nxt;
  logic [3:0]                   wbr_r, wbr_nxt;
  logic [bxds_pkg::BX_W-1:0]    bcol_r, bcol_nxt;
  logic [bxds_pkg::POS_W-1:0]   bstart_r, bstart_nxt;
  logic [bxds_pkg::POS_W-1:0]   rstart_r, rstart_nxt;

  logic [bxds_pkg::POS_W-1:0]   s_pos;
  logic [bxds_pkg::DIM_W-1:0]   pcol_inc;
  logic [bxds_pkg::DIM_W-1:0]   prow_inc;
  logic                         row_wrap, frame_wrap, wbc_wrap, wbr_wrap;
  logic                         act, blk_end, emit, row_last, frame_last;

  bxds_pkg::tag_t               t1_r, t2_r, t3_r;
  bxds_pkg::tag_t               t1_nxt;

  always_comb begin
    restart    = 1'b0;
    scale_nxt  = scale_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (bxds_pkg::cfg_idx_t'(cfg_index))
        bxds_pkg::CFG_SCALE: begin
          scale_nxt = cfg_data[bxds_pkg::SCALE_W-1:0];
          restart   = 1'b1;
        end
        bxds_pkg::CFG_WIDTH: begin
          width_nxt = cfg_data;
          restart   = 1'b1;
        end
        bxds_pkg::CFG_HEIGHT: begin
          height_nxt = cfg_data;
          restart    = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    if (scale_r == '0) s_eff = bxds_pkg::SCALE_W'(1);
    else if (scale_r > bxds_pkg::SCALE_W'(bxds_pkg::MAX_SCALE))
      s_eff = bxds_pkg::SCALE_W'(bxds_pkg::MAX_SCALE);
    else s_eff = scale_r;

    if (width_r == '0) w_eff = bxds_pkg::DIM_W'(1);
    else if (width_r > bxds_pkg::DIM_W'(bxds_pkg::MAX_WIDTH))
      w_eff = bxds_pkg::DIM_W'(bxds_pkg::MAX_WIDTH);
    else w_eff = width_r;

    if (height_r == '0) h_eff = bxds_pkg::DIM_W'(1);
    else if (height_r > bxds_pkg::DIM_W'(bxds_pkg::HEIGHT_LIMIT))
      h_eff = bxds_pkg::DIM_W'(bxds_pkg::HEIGHT_LIMIT);
    else h_eff = height_r;
  end

  assign s_pos    = bxds_pkg::POS_W'(s_eff);
  assign pcol_inc = {1'b0, pcol_r} + bxds_pkg::DIM_W'(1);
  assign prow_inc = {1'b0, prow_r} + bxds_pkg::DIM_W'(1);
  assign row_wrap   = pcol_inc >= w_eff;
  assign frame_wrap = prow_inc >= h_eff;
  assign wbc_wrap   = ({1'b0, wbc_r} + 5'd1) >= s_eff;
  assign wbr_wrap   = ({1'b0, wbr_r} + 5'd1) >= s_eff;

  assign act = ((bstart_r + s_pos) <= {1'b0, w_eff}) &&
               ((rstart_r + s_pos) <= {1'b0, h_eff});
  assign blk_end    = act && ({1'b0, wbc_r} == (s_eff - 5'd1));
  assign emit       = blk_end && ({1'b0, wbr_r} == (s_eff - 5'd1));
  assign row_last   = (bstart_r + (s_pos << 1)) > {1'b0, w_eff};
  assign frame_last = row_last && ((rstart_r + (s_pos << 1)) > {1'b0, h_eff});

  always_comb begin
    pcol_nxt   = pcol_r;
    prow_nxt   = prow_r;
    wbc_nxt    = wbc_r;
    wbr_nxt    = wbr_r;
    bcol_nxt   = bcol_r;
    bstart_nxt = bstart_r;
    rstart_nxt = rstart_r;
    if (restart) begin
      pcol_nxt   = '0;
      prow_nxt   = '0;
      wbc_nxt    = '0;
      wbr_nxt    = '0;
      bcol_nxt   = '0;
      bstart_nxt = '0;
      rstart_nxt = '0;
    end else if (acc) begin
      if (row_wrap) begin
        pcol_nxt   = '0;
        wbc_nxt    = '0;
        bcol_nxt   = '0;
        bstart_nxt = '0;
        if (frame_wrap) begin
          prow_nxt   = '0;
          wbr_nxt    = '0;
          rstart_nxt = '0;
        end else begin
          prow_nxt = prow_inc[bxds_pkg::BX_W-1:0];
          if (wbr_wrap) begin
            wbr_nxt    = '0;
            rstart_nxt = rstart_r + s_pos;
          end else begin
            wbr_nxt = wbr_r + 4'd1;
          end
        end
      end else begin
        pcol_nxt = pcol_inc[bxds_pkg::BX_W-1:0];
        if (wbc_wrap) begin
          wbc_nxt    = '0;
          bcol_nxt   = bcol_r + bxds_pkg::BX_W'(1);
          bstart_nxt = bstart_r + s_pos;
        end else begin
          wbc_nxt = wbc_r + 4'd1;
        end
      end
    end
  end

  always_comb begin
    ctl.acc      = acc;
    ctl.restart  = restart;
    ctl.act      = act;
    ctl.blk_end  = blk_end;
    ctl.first    = (wbr_r == '0);
    ctl.row_wrap = row_wrap;
    ctl.bx       = bcol_r;
    t1_nxt.vld       = acc && !restart && emit;
    t1_nxt.row_end   = row_last;
    t1_nxt.frame_end = frame_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= bxds_pkg::SCALE_W'(1);
      width_r  <= bxds_pkg::DIM_W'(640);
      height_r <= bxds_pkg::DIM_W'(480);
      pcol_r   <= '0;
      prow_r   <= '0;
      wbc_r    <= '0;
      wbr_r    <= '0;
      bcol_r   <= '0;
      bstart_r <= '0;
      rstart_r <= '0;
      t1_r     <= '0;
      t2_r     <= '0;
      t3_r     <= '0;
    end else begin
      scale_r  <= scale_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      pcol_r   <= pcol_nxt;
      prow_r   <= prow_nxt;
      wbc_r    <= wbc_nxt;
      wbr_r    <= wbr_nxt;
      bcol_r   <= bcol_nxt;
      bstart_r <= bstart_nxt;
      rstart_r <= rstart_nxt;
      t1_r     <= t1_nxt;
      t2_r     <= t1_r;
      t3_r     <= t2_r;
    end
  end

  assign recip    = bxds_pkg::recip_of(s_eff);
  assign tag      = t3_r;
  assign inflight = 2'({1'b0, t1_r.vld} + {1'b0, t2_r.vld} + {1'b0, t3_r.vld});

endmodule

@@ sv/bxds_lane.sv @@
// One color channel: running block sum, per-column partial sum store, and
// reciprocal-multiply mean. Uses bxds_pkg.
module bxds_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bxds_pkg::lane_ctl_t            ctl,
  input  logic [bxds_pkg::CH_W-1:0]      px,
  input  logic [bxds_pkg::RECIP_W-1:0]   recip,
  output logic [bxds_pkg::CH_W-1:0]      avg
);

  logic [bxds_pkg::SUM_W-1:0]  mem [bxds_pkg::MAX_WIDTH];

  logic [bxds_pkg::SUM_W-1:0]  run_r, run_nxt;
  logic [bxds_pkg::SUM_W-1:0]  sum;
  logic                        wr1_r, wr1_nxt;
  logic                        first1_r;
  logic [bxds_pkg::BX_W-1:0]   bx1_r;
  logic [bxds_pkg::SUM_W-1:0]  bsum1_r;
  logic [bxds_pkg::SUM_W-1:0]  rd_r;
  logic [bxds_pkg::SUM_W-1:0]  col;
  logic [bxds_pkg::SUM_W-1:0]  col_r;
  logic [bxds_pkg::PROD_W-1:0] prod_r;

  assign sum = run_r + bxds_pkg::SUM_W'(px);

  always_comb begin
    run_nxt = run_r;
    wr1_nxt = 1'b0;
    if (ctl.restart) begin
      run_nxt = '0;
    end else if (ctl.acc) begin
      if (ctl.act) begin
        run_nxt = ctl.blk_end ? '0 : sum;
        wr1_nxt = ctl.blk_end;
      end
      if (ctl.row_wrap) run_nxt = '0;
    end
  end

  assign col = first1_r ? bsum1_r : (rd_r + bsum1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
      wr1_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      wr1_r <= wr1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= ctl.first;
    bx1_r    <= ctl.bx;
    bsum1_r  <= sum;
    col_r    <= col;
    prod_r   <= bxds_pkg::PROD_W'(col_r) * bxds_pkg::PROD_W'(recip);
  end

  always_ff @(posedge clk) begin
    if (wr1_r) mem[bx1_r] <= col;
    rd_r <= mem[ctl.bx];
  end

  assign avg = prod_r[bxds_pkg::RECIP_SH + bxds_pkg::CH_W - 1 : bxds_pkg::RECIP_SH];

endmodule

@@ sv/bxds_merge.sv @@
// Merge stage: joins the three lane means with the row and frame flags and
// queues the words for the output channel. Uses bxds_pkg.
module bxds_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bxds_pkg::tag_t                tag,
  input  logic [bxds_pkg::CH_W-1:0]     avg_blue,
  input  logic [bxds_pkg::CH_W-1:0]     avg_green,
  input  logic [bxds_pkg::CH_W-1:0]     avg_red,
  input  logic                          pop,
  output bxds_pkg::out_word_t           word,
  output logic [bxds_pkg::CNT_W-1:0]    cnt
);

  bxds_pkg::out_word_t            q_r [bxds_pkg::FIFO_DEPTH];
  bxds_pkg::out_word_t            push_word;
  logic [bxds_pkg::FIFO_AW-1:0]   wp_r, wp_nxt;
  logic [bxds_pkg::FIFO_AW-1:0]   rp_r, rp_nxt;
  logic [bxds_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;

  always_comb begin
    push_word.avg_blue  = avg_blue;
    push_word.avg_green = avg_green;
    push_word.avg_red   = avg_red;
    push_word.row_end   = tag.row_end;
    push_word.frame_end = tag.frame_end;
  end

  always_comb begin
    wp_nxt  = tag.vld ? wp_r + bxds_pkg::FIFO_AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + bxds_pkg::FIFO_AW'(1) : rp_r;
    cnt_nxt = cnt_r + bxds_pkg::CNT_W'(tag.vld) - bxds_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tag.vld) q_r[wp_r] <= push_word;
  end

  assign word = q_r[rp_r];
  assign cnt  = cnt_r;

endmodule

@@ verif/tb_box_average_downscaler_top.sv @@
// Self-checking testbench for box_average_downscaler_top: random and directed pixel streams
// against a block-mean predictor kept in a small scoreboard class.
// Depends on bxds_pkg and box_average_downscaler_top.
module tb_box_average_downscaler_top;

  localparam logic [bxds_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  class box_mean_board;
    bit [bxds_pkg::SCALE_W-1:0] scale_reg = 5'd1;
    bit [bxds_pkg::DIM_W-1:0] width_reg = 12'd640;
    bit [bxds_pkg::DIM_W-1:0] height_reg = 12'd480;
    bit [bxds_pkg::SUM_W-1:0] col_sum [3][bxds_pkg::MAX_WIDTH];
    bit [bxds_pkg::SUM_W-1:0] blk_sum [3];
    int unsigned px_col, px_row, in_col, in_row;
    bxds_pkg::out_word_t expected_words[$];
    int errors, pixels, words;

    task report(string msg);
      errors++;
      $display("MISMATCH %s", msg);
    endtask

    function int pending();
      return expected_words.size();
    endfunction

    function void restart();
      int k;
      for (k = 0; k < 3; k++) blk_sum[k] = '0;
      px_col = 0;
      px_row = 0;
      in_col = 0;
      in_row = 0;
    endfunction

    function void set_reg(logic [bxds_pkg::CFG_IDX_W-1:0] idx,
                          logic [bxds_pkg::DIM_W-1:0] data);
      case (idx)
        bxds_pkg::CFG_SCALE: begin
          scale_reg = data[bxds_pkg::SCALE_W-1:0];
          restart();
        end
        bxds_pkg::CFG_WIDTH: begin
          width_reg = data;
          restart();
        end
        bxds_pkg::CFG_HEIGHT: begin
          height_reg = data;
          restart();
        end
        default: ;
      endcase
    endfunction

    function void note_pixel(bit [bxds_pkg::CH_W-1:0] blue, bit [bxds_pkg::CH_W-1:0] green,
                             bit [bxds_pkg::CH_W-1:0] red);
      int unsigned s, w, h, ow, oh, bx;
      int k;
      bit [bxds_pkg::CH_W-1:0] chan [3];
      bxds_pkg::out_word_t word;
      s = (scale_reg == 0) ? 1 :
          (scale_reg > bxds_pkg::MAX_SCALE) ? bxds_pkg::MAX_SCALE : scale_reg;
      w = (width_reg == 0) ? 1 :
          (width_reg > bxds_pkg::MAX_WIDTH) ? bxds_pkg::MAX_WIDTH : width_reg;
      h = (height_reg == 0) ? 1 :
          (height_reg > bxds_pkg::HEIGHT_LIMIT) ? bxds_pkg::HEIGHT_LIMIT : height_reg;
      ow = w / s;
      oh = h / s;
      chan[0] = blue;
      chan[1] = green;
      chan[2] = red;
      pixels++;
      if (px_col < ow * s && px_row < oh * s) begin
        for (k = 0; k < 3; k++) blk_sum[k] = blk_sum[k] + chan[k];
        if (in_col == s - 1) begin
          bx = (px_col / s) % bxds_pkg::MAX_WIDTH;
          for (k = 0; k < 3; k++) begin
            col_sum[k][bx] = (in_row == 0) ? blk_sum[k] : col_sum[k][bx] + blk_sum[k];
            blk_sum[k] = '0;
          end
          if (in_row == s - 1) begin
            word.avg_blue = 8'(col_sum[0][bx] / (s * s));
            word.avg_green = 8'(col_sum[1][bx] / (s * s));
            word.avg_red = 8'(col_sum[2][bx] / (s * s));
            word.row_end = (px_col / s) == ow - 1;
            word.frame_end = word.row_end && (px_row == oh * s - 1);
            expected_words = {expected_words, word};
          end
        end
      end
      in_col = (in_col + 1 >= s) ? 0 : in_col + 1;
      px_col++;
      if (px_col >= w) begin
        px_col = 0;
        in_col = 0;
        for (k = 0; k < 3; k++) blk_sum[k] = '0;
        in_row = (in_row + 1 >= s) ? 0 : in_row + 1;
        px_row++;
        if (px_row >= h) begin
          px_row = 0;
          in_row = 0;
        end
      end
    endfunction

    task compare_field(string name, int got, int want);
      if (got != want) report($sformatf("word %0d: %s got %0d want %0d", words, name, got, want));
    endtask

    task check_word(bxds_pkg::out_word_t got);
      bxds_pkg::out_word_t want;
      words++;
      if (expected_words.size() == 0) begin
        report($sformatf("word %0d arrived with nothing expected", words));
        return;
      end
      want = expected_words.pop_front();
      compare_field("avg_blue", got.avg_blue, want.avg_blue);
      compare_field("avg_green", got.avg_green, want.avg_green);
      compare_field("avg_red", got.avg_red, want.avg_red);
      compare_field("row_end", got.row_end, want.row_end);
      compare_field("frame_end", got.frame_end, want.frame_end);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [bxds_pkg::CH_W-1:0] in_blue = '0;
  logic [bxds_pkg::CH_W-1:0] in_green = '0;
  logic [bxds_pkg::CH_W-1:0] in_red = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [bxds_pkg::CH_W-1:0] out_avg_blue, out_avg_green, out_avg_red;
  logic out_row_end, out_frame_end;
  logic cfg_we = 1'b0;
  logic [bxds_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bxds_pkg::DIM_W-1:0] cfg_data = '0;

  box_mean_board board = new();
  int tx_pct = 0;
  int rx_pct = 0;
  int cycle_count = 0;
  int settings = 0;

  box_average_downscaler_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_blue(in_blue),
    .in_green(in_green),
    .in_red(in_red),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_avg_blue(out_avg_blue),
    .out_avg_green(out_avg_green),
    .out_avg_red(out_avg_red),
    .out_row_end(out_row_end),
    .out_frame_end(out_frame_end),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_word({out_avg_blue, out_avg_green, out_avg_red, out_row_end, out_frame_end});
    out_stall <= (rx_pct != 0) && ($urandom_range(0, 99) < rx_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycle_count, board.pending());
      $display("** box_average_downscaler_top: FAILED **");
      $finish;
    end
  end

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        tx_pct = 46;
        rx_pct <= 0;
      end
      IDLE_RECEIVER: begin
        tx_pct = 0;
        rx_pct <= 46;
      end
      IDLE_BOTH: begin
        tx_pct = 29;
        rx_pct <= 29;
      end
      default: begin
        tx_pct = 0;
        rx_pct <= 0;
      end
    endcase
  endtask

  task automatic send_pixel(logic [bxds_pkg::CH_W-1:0] blue, logic [bxds_pkg::CH_W-1:0] green,
                            logic [bxds_pkg::CH_W-1:0] red);
    while (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue <= blue;
    in_green <= green;
    in_red <= red;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pixel(blue, green, red);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic settle();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [bxds_pkg::CFG_IDX_W-1:0] idx,
                           logic [bxds_pkg::DIM_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  task automatic run_phase(int s_reg, int w_reg, int h_reg, int npix, idle_mode_t mode,
                           bit pause, bit rewrite, bit spare);
    int i;
    settle();
    if (rewrite) begin
      write_reg(bxds_pkg::CFG_SCALE, {7'($urandom), 5'(s_reg)});
      write_reg(bxds_pkg::CFG_WIDTH, 12'(w_reg));
      write_reg(bxds_pkg::CFG_HEIGHT, 12'(h_reg));
    end
    if (spare) write_reg(CFG_SPARE, 12'($urandom));
    cfg_we <= 1'b0;
    set_idling(mode);
    settings++;
    for (i = 0; i < npix; i++) begin
      if (pause && i == npix / 2) hold_until_drained();
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int row, col, k, phase_no, rand_pixels;
    int s_reg, s_eff, w_reg, h_reg, w_eff, h_eff, frame, npix;
    logic [bxds_pkg::CH_W-1:0] v;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, then a spare-index write that must not restart the frame
    run_phase(0, 0, 0, 20, IDLE_NONE, 1'b0, 1'b0, 1'b0);
    run_phase(0, 0, 0, 10, IDLE_RECEIVER, 1'b0, 1'b0, 1'b1);

    // 2x2 blocks on a 5x4 image: full-scale, zero and truncated means, dropped column
    settle();
    write_reg(bxds_pkg::CFG_SCALE, 12'd2);
    write_reg(bxds_pkg::CFG_WIDTH, 12'd5);
    write_reg(bxds_pkg::CFG_HEIGHT, 12'd4);
    cfg_we <= 1'b0;
    set_idling(IDLE_NONE);
    settings++;
    for (row = 0; row < 4; row++) begin
      for (col = 0; col < 5; col++) begin
        if (row == 2 && col == 0) hold_until_drained();
        if (col == 4) v = 8'hA5;
        else if (row < 2) v = (col < 2) ? 8'hFF : 8'h00;
        else v = ((row + col) % 2 != 0) ? 8'hFE : 8'h01;
        send_pixel(v, ~v, v ^ 8'h5A);
      end
    end

    run_phase(0, 0, 0, 6, IDLE_SENDER, 1'b0, 1'b1, 1'b0);
    run_phase(31, 17, 16, 17 * 15 + 16, IDLE_BOTH, 1'b0, 1'b1, 1'b0);
    run_phase(8, 7, 20, 30, IDLE_RECEIVER, 1'b0, 1'b1, 1'b1);
    run_phase(1, 4095, 1, 30, IDLE_BOTH, 1'b1, 1'b1, 1'b0);
    run_phase(1, 1, 4095, 30, IDLE_NONE, 1'b0, 1'b1, 1'b0);
    run_phase(16, 2048, 2048, 20, IDLE_SENDER, 1'b0, 1'b1, 1'b0);

    phase_no = 0;
    rand_pixels = 0;
    while (rand_pixels < 220) begin
      k = $urandom_range(0, 99);
      if (k < 5) s_reg = 0;
      else if (k < 12) s_reg = $urandom_range(17, 31);
      else if (k < 22) s_reg = $urandom_range(5, 16);
      else s_reg = $urandom_range(1, 4);
      s_eff = (s_reg == 0) ? 1 : (s_reg > bxds_pkg::MAX_SCALE) ? bxds_pkg::MAX_SCALE : s_reg;
      k = $urandom_range(0, 99);
      if (k < 8) begin
        w_reg = $urandom_range(0, s_eff);
        h_reg = $urandom_range(0, 2 * s_eff + 1);
      end else if (s_eff > 4) begin
        w_reg = s_eff * $urandom_range(1, 2) + $urandom_range(0, 3);
        h_reg = s_eff + $urandom_range(0, 2);
      end else begin
        w_reg = s_eff * $urandom_range(1, 4) + $urandom_range(0, s_eff - 1);
        h_reg = s_eff * $urandom_range(1, 3) + $urandom_range(0, s_eff - 1);
      end
      w_eff = (w_reg == 0) ? 1 : w_reg;
      h_eff = (h_reg == 0) ? 1 : h_reg;
      frame = w_eff * h_eff;
      npix = (frame > 200) ? frame : frame * $urandom_range(1, 2) + $urandom_range(0, w_eff);
      if (npix > 80) npix = 80;
      run_phase(s_reg, w_reg, h_reg, npix, idle_mode_t'(phase_no % 4),
                $urandom_range(0, 4) == 0, $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0);
      rand_pixels += npix;
      phase_no++;
    end

    settle();
    $display("Run covered %0d pixels over %0d settings; %0d averaged words checked, %0d mismatches",
             board.pixels, settings, board.words, board.errors);
    if (board.errors == 0)
      $display("** box_average_downscaler_top: PASSED **");
    else
      $display("** box_average_downscaler_top: FAILED **");
    $finish;
  end
endmodule
